@@ sv/vwd_pkg.sv @@
// ----------------------------------------------------------------------------
// vwd_pkg: shared types and constants of the vertex weld block
// command and status codes, widths, channel beats, controller-datapath
// command and status structs
// ----------------------------------------------------------------------------
package vwd_pkg;

   localparam int MaxVertsDefault = 1024;
   localparam int FaceVertsDefault = 64;
   localparam int CompW = 32;
   localparam int LocalW = 6;
   localparam int IndexW = 10;
   localparam int StatusW = 3;
   localparam int CmdW = 2;
   localparam logic [31:0] ThresholdReset = 32'd4295;
   localparam int OneUnit = 65536;

   typedef enum logic [CmdW-1:0] {
      CMD_ADD   = 2'd0,
      CMD_XLATE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      ST_APPENDED = 3'd0,
      ST_WELDED   = 3'd1,
      ST_INDEX    = 3'd2,
      ST_FULL     = 3'd3,
      ST_BAD_IDX  = 3'd4
   } status_type;

   // one vertex: 8 components
   typedef logic signed [CompW-1:0] comp_type;
   typedef comp_type [7:0] vertex_type;

   // request beat, fields in channel order
   typedef struct packed {
      cmd_type                command;
      logic                   first_of_face;
      comp_type               pos_x;
      comp_type               pos_y;
      comp_type               pos_z;
      comp_type               tex_u;
      comp_type               tex_v;
      comp_type               norm_x;
      comp_type               norm_y;
      comp_type               norm_z;
      logic [LocalW-1:0]      local_index;
   } req_type;

   // response beat
   typedef struct packed {
      status_type             status;
      logic [IndexW-1:0]      mesh_index;
   } rsp_type;

   // register write beat
   typedef struct packed {
      logic [31:0]            weld_threshold_sq;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch the request
      logic clear_face; // face count to zero
      logic clear_mesh; // vertex and face counts to zero
      logic scan_start; // reset scan index
      logic scan_step;  // issue a read at scan index, advance
      logic append;     // write the held vertex at vertex_count
      logic remap;      // record found index into face remap
      logic rd_remap;   // read the remap at local index
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;  // all stored entries issued
      logic cmp_valid;  // a compare result is at the tail
      logic cmp_hit;    // that result matched
      logic pipe_empty; // no compare in flight
      logic table_full;
      logic local_bad;
   } sts_type;

endpackage

@@ sv/vwd_chan_if.sv @@
// ----------------------------------------------------------------------------
// vwd_chan_if: valid/ready channel
// generic payload beat carrier with source and sink views
// ----------------------------------------------------------------------------
interface vwd_chan_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/vwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// vwd_ctrl: sequencer of the vertex weld block
// walks adds through scan, append and remap, translates through a remap read, and both to a response
// ----------------------------------------------------------------------------
module vwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vwd_pkg::cmd_type       req_cmd,
   input  logic                   req_first,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vwd_pkg::status_type    rsp_status,
   output logic                   rsp_use_found,
   output vwd_pkg::ctl_type       ctl,
   input  vwd_pkg::sts_type       sts
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DRAIN = 6'b000100,
      S_XLATE = 6'b001000,
      S_RESP  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   vwd_pkg::status_type status_ff, status_in;
   logic use_found_ff, use_found_in;

   // accept: idle, or response being taken
   assign req_ready = (state_ff == S_IDLE) ||
                      (state_ff == S_RESP && rsp_ready);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_use_found = use_found_ff;

   logic take;
   assign take = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      use_found_in = use_found_ff;
      ctl = '0;
      if (state_ff == S_RESP && rsp_ready) begin
         state_in = S_IDLE;
      end
      case (state_ff)
         S_IDLE, S_RESP: begin
            if (take) begin
               ctl.load = 1'b1;
               case (req_cmd)
                  vwd_pkg::CMD_ADD: begin
                     ctl.clear_face = req_first;
                     ctl.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
                  vwd_pkg::CMD_XLATE: begin
                     state_in = S_XLATE;
                  end
                  vwd_pkg::CMD_CLEAR: begin
                     ctl.clear_mesh = 1'b1;
                     state_in = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (sts.cmp_valid && sts.cmp_hit) begin
               state_in = S_DRAIN;
            end else if (!sts.scan_done) begin
               ctl.scan_step = 1'b1;
            end else if (sts.pipe_empty) begin
               state_in = S_DONE;
            end
         end
         S_DRAIN: begin
            // hit captured; wait for in-flight reads to flush
            if (sts.pipe_empty) begin
               ctl.remap = 1'b1;
               status_in = vwd_pkg::ST_WELDED;
               use_found_in = 1'b1;
               state_in = S_RESP;
            end
         end
         S_DONE: begin
            if (sts.table_full) begin
               status_in = vwd_pkg::ST_FULL;
               use_found_in = 1'b0;
            end else begin
               ctl.append = 1'b1;
               ctl.remap = 1'b1;
               status_in = vwd_pkg::ST_APPENDED;
               use_found_in = 1'b1;
            end
            state_in = S_RESP;
         end
         S_XLATE: begin
            ctl.rd_remap = 1'b1;
            if (sts.local_bad) begin
               status_in = vwd_pkg::ST_BAD_IDX;
               use_found_in = 1'b0;
            end else begin
               status_in = vwd_pkg::ST_INDEX;
               use_found_in = 1'b1;
            end
            state_in = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= vwd_pkg::ST_APPENDED;
         use_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         use_found_ff <= use_found_in;
      end
   end

   // response only from the response state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != S_IDLE || $past(rsp_valid))
      else $error("response without work");
   // no scan command outside scan
   a_step_scan: assert property (@(posedge clock) disable iff (reset)
      ctl.scan_step |-> state_ff == S_SCAN)
      else $error("scan step outside scan");
   // append and full never together
   a_append_full: assert property (@(posedge clock) disable iff (reset)
      ctl.append |-> !sts.table_full)
      else $error("append into full table");

endmodule

@@ sv/vwd_dp.sv @@
// ----------------------------------------------------------------------------
// vwd_dp: datapath of the vertex weld block
// vertex store, compare pipeline, counters and face remap
// ----------------------------------------------------------------------------
module vwd_dp #(
   parameter int MAX_VERTS = vwd_pkg::MaxVertsDefault,
   parameter int FACE_VERTS = vwd_pkg::FaceVertsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [31:0]                   threshold,
   input  vwd_pkg::vertex_type           req_vertex,
   input  logic [vwd_pkg::LocalW-1:0]    req_local,
   input  vwd_pkg::ctl_type              ctl,
   output vwd_pkg::sts_type              sts,
   input  logic                          rsp_use_found,
   output logic [vwd_pkg::IndexW-1:0]    rsp_index
);

   localparam int VA = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam int VC = $clog2(MAX_VERTS + 1);
   localparam int FA = (FACE_VERTS > 1) ? $clog2(FACE_VERTS) : 1;
   localparam int FC = $clog2(FACE_VERTS + 1);
   localparam int LW = (FC > vwd_pkg::LocalW) ? FC : vwd_pkg::LocalW;
   localparam int SqW = 34;

   // vertex store, one word holds all eight components
   vwd_pkg::vertex_type store_mem [MAX_VERTS];
   logic [VA-1:0] face_remap_mem [FACE_VERTS];

   vwd_pkg::vertex_type vert_ff;
   logic [vwd_pkg::LocalW-1:0] local_ff;
   logic [VC-1:0] vcount_ff, vcount_in;
   logic [FC-1:0] fcount_ff, fcount_in;
   logic [VC-1:0] scan_ff, scan_in;
   logic [VA-1:0] found_ff;
   logic [VA-1:0] remap_rd_ff;
   logic hit_seen_ff;

   // pipeline: read, diff, square, sum/compare
   logic v1_ff, v2_ff, v3_ff;
   logic [VA-1:0] a1_ff, a2_ff, a3_ff;
   vwd_pkg::vertex_type rd_ff;
   logic [7:0] big_ff;
   logic [15:0] mag_ff [8];
   logic [SqW-1:0] sq_ff [8];
   logic [7:0] big2_ff;

   // latch request
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         vert_ff <= req_vertex;
         local_ff <= req_local;
      end
   end

   // counters
   always_comb begin
      vcount_in = vcount_ff;
      fcount_in = fcount_ff;
      scan_in = scan_ff;
      if (ctl.scan_start) scan_in = '0;
      if (ctl.scan_step) scan_in = scan_ff + VC'(1);
      if (ctl.append) vcount_in = vcount_ff + VC'(1);
      if (ctl.remap && fcount_ff < FC'(FACE_VERTS)) fcount_in = fcount_ff + FC'(1);
      if (ctl.clear_face) fcount_in = '0;
      if (ctl.clear_mesh) begin
         vcount_in = '0;
         fcount_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         fcount_ff <= '0;
         scan_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         hit_seen_ff <= 1'b0;
      end else begin
         vcount_ff <= vcount_in;
         fcount_ff <= fcount_in;
         scan_ff <= scan_in;
         v1_ff <= ctl.scan_step;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (ctl.scan_start) hit_seen_ff <= 1'b0;
         else if (sts.cmp_valid && sts.cmp_hit) hit_seen_ff <= 1'b1;
      end
   end

   // store write and read
   always_ff @(posedge clock) begin
      if (ctl.append) store_mem[vcount_ff[VA-1:0]] <= vert_ff;
      rd_ff <= store_mem[scan_ff[VA-1:0]];
      a1_ff <= scan_ff[VA-1:0];
   end

   // difference magnitudes
   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         logic signed [vwd_pkg::CompW:0] d;
         logic [vwd_pkg::CompW:0] m;
         d = {rd_ff[k][vwd_pkg::CompW-1], rd_ff[k]} -
             {vert_ff[k][vwd_pkg::CompW-1], vert_ff[k]};
         m = d[vwd_pkg::CompW] ? -d : d;
         big_ff[k] <= m >= (vwd_pkg::CompW+1)'(vwd_pkg::OneUnit);
         mag_ff[k] <= m[15:0];
      end
      a2_ff <= a1_ff;
   end

   // squares
   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         sq_ff[k] <= SqW'({16'd0, mag_ff[k]} * {16'd0, mag_ff[k]});
      end
      big2_ff <= big_ff;
      a3_ff <= a2_ff;
   end

   // group sums and compare
   logic [SqW-1:0] s_pos, s_tex, s_nrm;
   logic hit;
   always_comb begin
      s_pos = sq_ff[0] + sq_ff[1] + sq_ff[2];
      s_tex = sq_ff[3] + sq_ff[4];
      s_nrm = sq_ff[5] + sq_ff[6] + sq_ff[7];
      hit = (big2_ff == 8'd0) && s_pos < {2'b0, threshold} &&
            s_tex < {2'b0, threshold} && s_nrm < {2'b0, threshold};
   end

   // first hit index
   always_ff @(posedge clock) begin
      if (v3_ff && hit && !hit_seen_ff) found_ff <= a3_ff;
      else if (ctl.append) found_ff <= vcount_ff[VA-1:0];
   end

   // face remap; appended index is the count before increment
   logic [VA-1:0] remap_val;
   logic [FA-1:0] local_addr;
   assign remap_val = (ctl.append) ? vcount_ff[VA-1:0] : found_ff;
   assign local_addr = FA'(local_ff);
   always_ff @(posedge clock) begin
      if (ctl.remap && fcount_ff < FC'(FACE_VERTS))
         face_remap_mem[fcount_ff[FA-1:0]] <= remap_val;
      if (ctl.rd_remap) remap_rd_ff <= face_remap_mem[local_addr];
   end

   logic rd_sel_ff;
   always_ff @(posedge clock) begin
      if (reset) rd_sel_ff <= 1'b0;
      else if (ctl.rd_remap) rd_sel_ff <= 1'b1;
      else if (ctl.load || ctl.remap) rd_sel_ff <= 1'b0;
   end

   logic [VA-1:0] idx_full;
   assign idx_full = rd_sel_ff ? remap_rd_ff : found_ff;
   assign rsp_index = rsp_use_found ? vwd_pkg::IndexW'({{vwd_pkg::IndexW{1'b0}}, idx_full})
                                    : '0;

   // status
   assign sts.scan_done = scan_ff >= vcount_ff;
   assign sts.cmp_valid = v3_ff && !hit_seen_ff;
   assign sts.cmp_hit = hit;
   assign sts.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign sts.table_full = vcount_ff >= VC'(MAX_VERTS);
   assign sts.local_bad = (LW'(local_ff) >= LW'(fcount_ff)) ||
                          (LW'(local_ff) >= LW'(FACE_VERTS));

   // counts stay in range
   a_vcount: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VC'(MAX_VERTS))
      else $error("vertex count overflow");
   a_fcount: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= FC'(FACE_VERTS))
      else $error("face count overflow");
   // compare pipe advances in lockstep
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff)
      else $error("compare pipe lost a beat");

endmodule

@@ sv/vertex_weld_dedup.sv @@
// ----------------------------------------------------------------------------
// vertex_weld_dedup: deduplicated vertex table builder
// An add beat compares the vertex against every stored vertex through a
// four-stage compare pipeline fed by one read port of the vertex memory, one
// entry per cycle; a weld ends the scan early. Translate beats read the face
// remap and then respond; clear beats finish at acceptance and give no
// response. One item is worked on at a time; the response register lets the
// next beat be taken while the response is delivered.
// ----------------------------------------------------------------------------
module vertex_weld_dedup #(
   parameter int MAX_VERTS = vwd_pkg::MaxVertsDefault,
   parameter int FACE_VERTS = vwd_pkg::FaceVertsDefault
) (
   input  logic  clock,
   input  logic  reset,
   vwd_chan_if.sink   req,
   vwd_chan_if.source rsp,
   vwd_chan_if.sink   csr
);

   logic [31:0] threshold_ff;
   vwd_pkg::ctl_type ctl;
   vwd_pkg::sts_type sts;
   vwd_pkg::status_type st;
   logic use_found;
   logic [vwd_pkg::IndexW-1:0] idx;
   vwd_pkg::vertex_type vert;

   // threshold register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) threshold_ff <= vwd_pkg::ThresholdReset;
      else if (csr.valid) threshold_ff <= csr.data.weld_threshold_sq;
   end

   // gather components
   assign vert[0] = req.data.pos_x;
   assign vert[1] = req.data.pos_y;
   assign vert[2] = req.data.pos_z;
   assign vert[3] = req.data.tex_u;
   assign vert[4] = req.data.tex_v;
   assign vert[5] = req.data.norm_x;
   assign vert[6] = req.data.norm_y;
   assign vert[7] = req.data.norm_z;

   vwd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_cmd(vwd_pkg::cmd_type'(req.data.command)),
      .req_first(req.data.first_of_face),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(st), .rsp_use_found(use_found),
      .ctl(ctl), .sts(sts)
   );

   vwd_dp #(.MAX_VERTS(MAX_VERTS), .FACE_VERTS(FACE_VERTS)) u_dp (
      .clock(clock), .reset(reset), .threshold(threshold_ff),
      .req_vertex(vert), .req_local(req.data.local_index),
      .ctl(ctl), .sts(sts), .rsp_use_found(use_found), .rsp_index(idx)
   );

   assign rsp.data.status = st;
   assign rsp.data.mesh_index = idx;

endmodule
